@@ src/accel_magnitude_normalize_quantize_assert.svh @@
// assertion macros shared by the rtl
`ifndef ACCEL_MAGNITUDE_NORMALIZE_QUANTIZE_ASSERT_SVH
`define ACCEL_MAGNITUDE_NORMALIZE_QUANTIZE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AMNQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define AMNQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/amnq_pkg.sv @@
package amnq_pkg;

  localparam int FRAME_SAMPLES = 32;
  localparam int IDX_W         = $clog2(FRAME_SAMPLES);
  localparam int CNT_W         = $clog2(FRAME_SAMPLES + 1);
  localparam int SAMPLE_BITS   = 16;
  localparam int SUM_W         = 2 * SAMPLE_BITS;
  localparam int FRAC_SHIFT    = 8;
  localparam int RAD_W         = SUM_W + FRAC_SHIFT;
  localparam int MAG_W         = RAD_W / 2;
  localparam int REM_W         = MAG_W + 1;
  localparam int QB_W          = 5;
  localparam int QB_RESET      = 8;
  localparam int QB_MAX        = 16;
  localparam int LEVEL_W       = 16;
  localparam int PROD_W        = MAG_W + LEVEL_W;
  localparam int NUM_W         = PROD_W + 2;
  localparam int DIV_STEPS     = LEVEL_W;
  localparam int STEP_W        = $clog2(DIV_STEPS);
  localparam int ROOT_STEPS    = MAG_W;
  localparam int ROOT_CNT_W    = $clog2(ROOT_STEPS);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic                          frame_end;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   sample_index;
    logic [LEVEL_W-1:0] level;
    logic               zero_peak;
    logic               run_last;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_ACC,
    ST_ROOT,
    ST_STORE,
    ST_RD,
    ST_SCALE,
    ST_DIVLD,
    ST_DIV,
    ST_OUT
  } state_t;

  // 2^n - 1, n saturated at QB_MAX
  function automatic logic [LEVEL_W-1:0] scale_of(input logic [QB_W-1:0] qb);
    logic [QB_W-1:0]  n;
    logic [LEVEL_W:0] full;
    n    = (qb > QB_W'(QB_MAX)) ? QB_W'(QB_MAX) : qb;
    full = ((LEVEL_W + 1)'(1) << n) - (LEVEL_W + 1)'(1);
    return full[LEVEL_W-1:0];
  endfunction

endpackage

@@ src/amnq_in_if.sv @@
interface amnq_in_if;
  logic               valid;
  logic               ready;
  amnq_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/amnq_out_if.sv @@
interface amnq_out_if;
  logic                valid;
  logic                ready;
  amnq_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/amnq_cfg_if.sv @@
interface amnq_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [amnq_pkg::QB_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/amnq_isqrt.sv @@
module amnq_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [amnq_pkg::RAD_W-1:0] radicand,
  output amnq_pkg::sqrt_stat_t       stat,
  output logic [amnq_pkg::MAG_W-1:0] root
);
  import amnq_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0]      op_r;
  logic [REM_W-1:0]      rem_r;
  logic [MAG_W-1:0]      root_r;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;

  // one root bit per cycle: bring down two radicand bits, try 4*root+1
  assign rem_sh = {rem_r, op_r[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_r, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      op_r   <= op_r << 2;
      rem_r  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r <= {root_r[MAG_W-2:0], ge};
      cnt_r  <= cnt_r + ROOT_CNT_W'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

@@ src/accel_magnitude_normalize_quantize.sv @@
// Takes one three-axis sample per input word and stores its magnitude
// floor(16*sqrt(x^2+y^2+z^2)) while tracking the frame peak. A sample runs from
// one accepted word to the next through three passes of the shared multiplier
// for the squares, one to load the root, the bit-serial square root (one root
// bit per cycle), one to store and the idle state that takes the word. On the
// sample that carries frame_end, or the 32nd sample, the block emits one word
// per stored sample in input order, level = round_half_up(mag*(2^n-1)/peak);
// each passes through a store read, one multiply, a 16-step restoring divide
// and any wait on out_ch.ready. No input is taken during emission. A zero peak
// gives level 0 with zero_peak set. quant_bits above 16 acts as 16; the value
// held at the frame's last sample applies to the whole frame.
`include "accel_magnitude_normalize_quantize_assert.svh"

module accel_magnitude_normalize_quantize (
  input  logic       clk,
  input  logic       rst_n,
  amnq_in_if.sink    in_ch,
  amnq_out_if.source out_ch,
  amnq_cfg_if.sink   cfg_ch
);
  import amnq_pkg::*;

  state_t state_r, state_nxt;

  logic [QB_W-1:0]        quant_bits_r;
  logic [SAMPLE_BITS-1:0] ax_r, ay_r, az_r;
  logic                   fe_r;
  logic [SUM_W-1:0]       sum_r;
  logic [PROD_W-1:0]      prod_r;
  logic [MAG_W-1:0]       peak_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       k_r;
  logic [IDX_W-1:0]       last_idx_r;
  logic [LEVEL_W-1:0]     scale_r;
  logic                   zero_r;
  logic [MAG_W-1:0]       rd_data_r;
  logic [REM_W-1:0]       rem_r;
  logic [LEVEL_W-1:0]     low_r;
  logic [LEVEL_W-1:0]     quo_r;
  logic [STEP_W-1:0]      step_r;
  out_word_t              out_r;

  logic [MAG_W-1:0] mag_mem [FRAME_SAMPLES];

  logic [MAG_W-1:0]   mul_a;
  logic [LEVEL_W-1:0] mul_b;
  logic               sqrt_start;
  logic [RAD_W-1:0]   radicand;
  sqrt_stat_t         sqrt_st;
  logic [MAG_W-1:0]   root;
  logic [MAG_W-1:0]   peak_max;
  logic               frame_done;
  logic [NUM_W-1:0]   num;
  logic [REM_W-1:0]   divisor;
  logic [REM_W:0]     div_t;
  logic               div_ge;
  logic               in_take;
  logic               out_take;

  function automatic logic [SAMPLE_BITS-1:0] abs_of(input logic signed [SAMPLE_BITS-1:0] v);
    return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : v;
  endfunction

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;

  assign radicand   = {sum_r + prod_r[SUM_W-1:0], FRAC_SHIFT'(0)};
  assign peak_max   = (root > peak_r) ? root : peak_r;
  assign frame_done = fe_r || (cnt_r == CNT_W'(FRAME_SAMPLES - 1));
  assign num        = {1'b0, prod_r, 1'b0} + NUM_W'(peak_r);
  assign divisor    = {peak_r, 1'b0};
  assign div_t      = {rem_r, low_r[LEVEL_W-1]};
  assign div_ge     = (div_t >= (REM_W + 1)'(divisor));

  amnq_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (radicand),
    .stat     (sqrt_st),
    .root     (root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_take) state_nxt = ST_SQ_X;
      ST_SQ_X:  state_nxt = ST_SQ_Y;
      ST_SQ_Y:  state_nxt = ST_SQ_Z;
      ST_SQ_Z:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_ROOT;
      ST_ROOT:  if (sqrt_st.done) state_nxt = ST_STORE;
      ST_STORE: state_nxt = frame_done ? ST_RD : ST_IDLE;
      ST_RD:    state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DIVLD;
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV:   if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ch.ready) state_nxt = (k_r == last_idx_r) ? ST_IDLE : ST_RD;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    case (state_r)
      ST_SQ_X:  begin mul_a = MAG_W'(ax_r); mul_b = LEVEL_W'(ax_r); end
      ST_SQ_Y:  begin mul_a = MAG_W'(ay_r); mul_b = LEVEL_W'(ay_r); end
      ST_SQ_Z:  begin mul_a = MAG_W'(az_r); mul_b = LEVEL_W'(az_r); end
      ST_SCALE: begin mul_a = rd_data_r; mul_b = scale_r; end
      ST_ACC:   sqrt_start = 1'b1;
      default:  ;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.data  = out_r;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      quant_bits_r <= QB_W'(QB_RESET);
      peak_r       <= '0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) quant_bits_r <= cfg_ch.data;
      if (state_r == ST_STORE) begin
        peak_r <= peak_max;
        cnt_r  <= cnt_r + CNT_W'(1);
      end else if (state_r == ST_OUT && out_take && k_r == last_idx_r) begin
        peak_r <= '0;
        cnt_r  <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (in_take) begin
      ax_r <= abs_of(in_ch.data.accel_x);
      ay_r <= abs_of(in_ch.data.accel_y);
      az_r <= abs_of(in_ch.data.accel_z);
      fe_r <= in_ch.data.frame_end;
    end
    case (state_r)
      ST_SQ_Y: sum_r <= prod_r[SUM_W-1:0];
      ST_SQ_Z: sum_r <= sum_r + prod_r[SUM_W-1:0];
      ST_STORE: begin
        last_idx_r <= cnt_r[IDX_W-1:0];
        k_r        <= '0;
        scale_r    <= scale_of(quant_bits_r);
        zero_r     <= (peak_max == '0);
      end
      ST_DIVLD: begin
        // quotient fits LEVEL_W bits, so the top part is already below the divisor
        rem_r  <= num[NUM_W-2:LEVEL_W];
        low_r  <= num[LEVEL_W-1:0];
        step_r <= '0;
      end
      ST_DIV: begin
        rem_r  <= div_ge ? REM_W'(div_t - (REM_W + 1)'(divisor)) : REM_W'(div_t);
        low_r  <= low_r << 1;
        quo_r  <= {quo_r[LEVEL_W-2:0], div_ge};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          out_r.sample_index <= k_r;
          out_r.level        <= zero_r ? '0 : {quo_r[LEVEL_W-2:0], div_ge};
          out_r.zero_peak    <= zero_r;
          out_r.run_last     <= (k_r == last_idx_r);
        end
      end
      ST_OUT: if (out_take) k_r <= k_r + IDX_W'(1);
      default: ;
    endcase
  end

  // magnitude store
  always_ff @(posedge clk) begin
    if (state_r == ST_STORE) mag_mem[cnt_r[IDX_W-1:0]] <= root;
    rd_data_r <= mag_mem[k_r];
  end

  `AMNQ_ASSERT_NOW(a_level_in_range, out_ch.valid, out_ch.data.level <= scale_r, "level above scale")
  `AMNQ_ASSERT_NOW(a_zero_peak_level, out_ch.valid && out_ch.data.zero_peak, out_ch.data.level == '0, "zero peak with nonzero level")
  `AMNQ_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CNT_W'(FRAME_SAMPLES), "sample count overrun")
  `AMNQ_ASSERT_NEXT(a_frame_clear, out_take && out_ch.data.run_last, peak_r == '0 && cnt_r == '0 && in_ch.ready, "frame state not cleared")
  `AMNQ_ASSERT_NOW(a_root_done_state, sqrt_st.done, state_r == ST_ROOT, "root finished outside wait state")

endmodule
